### hw/rtl/sorted_list_insert_delete_defines.svh
// ----------------------------------------------------------------------------
// Sorted list insert/delete - assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication
`define SLID_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list check failed");

// next-cycle implication
`define SLID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list check failed");

`endif

### hw/rtl/slid_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list insert/delete - package
// Widths, command and status codes, controller states and cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package slid_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VAL_W        = 8;
    localparam int OP_W         = 2;
    localparam int STAT_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
        logic rot;
    } ctl_t;

endpackage

`default_nettype wire

### hw/rtl/slid_cell.sv
// ----------------------------------------------------------------------------
// Sorted list insert/delete - list cell
// Holds one entry, compares it with the key, and on insert takes the left neighbor's
// entry or the key, on delete or rotate the right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module slid_cell
    import slid_pkg::*;
(
    input  wire logic                    clk,
    input  wire ctl_t                    ctl,
    input  wire logic signed [VAL_W-1:0] key,
    input  wire logic                    occ,
    input  wire logic                    left_ge,
    input  wire logic        [VAL_W-1:0] left_data,
    input  wire logic        [VAL_W-1:0] right_data,
    output logic             [VAL_W-1:0] data,
    output logic                         ge,
    output logic                         hit
);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;
    logic                    ge_reg;
    logic                    hit_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (left_ge)
                data_next = left_data;
            else if (ge_reg)
                data_next = key;
        end
        else if (ctl.del)
        begin
            if (ge_reg)
                data_next = right_data;
        end
        else if (ctl.rot)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (ctl.cmp)
        begin
            ge_reg  <= !occ || (data_reg >= key);
            hit_reg <= occ && (data_reg == key);
        end
    end

    assign data = data_reg;
    assign ge   = ge_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

### hw/rtl/sorted_list_insert_delete.sv
// Insert and delete: compare in the accept cycle, then shift in S_EXEC once the output is free.
// Result of insert or delete is registered in S_EXEC once the output register is free.
// Read-out: the row rotates once per cycle through every cell (an empty list answers ST_EMPTY).
// Each read-out result also waits on m_axis_tready before the row advances.
// Reset clears the entry count and the output valid; entry contents stay undefined.
// ----------------------------------------------------------------------------
// Sorted list insert/delete - top level
// Ascending list of signed bytes in a row of cells with insert, delete and
// in-order read-out commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_delete
    import slid_pkg::*;
#(
    parameter  int CAPACITY = CAPACITY_DEF,
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int OUT_W    = ((STAT_W + VAL_W + CNT_W + 7) / 8) * 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [VAL_W-1:0] s_axis_tdata,   // value
    input  wire logic [OP_W-1:0]  s_axis_tuser,   // op
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [OUT_W-1:0] m_axis_tdata,   // status, entry, occupancy
    output logic                  m_axis_tlast    // last
);

    state_t                  state_reg, state_next;
    op_t                     op_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;

    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [VAL_W-1:0]        m_entry_reg, m_entry_next;
    logic                    m_last_reg, m_last_next;
    logic [CNT_W-1:0]        m_occ_reg, m_occ_next;

    ctl_t                    ctl;
    logic signed [VAL_W-1:0] key;
    logic [VAL_W-1:0]        cell_data [CAPACITY];
    logic [CAPACITY-1:0]     ge_vec;
    logic [CAPACITY-1:0]     hit_vec;

    logic accept;
    logic out_free;
    logic full;
    logic empty;
    logic found;
    logic emit;
    logic last_step;
    logic advance;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign found     = |hit_vec;
    assign emit      = (CNT_W'(idx_reg) < count_reg);
    assign last_step = (idx_reg == IDX_W'(CAPACITY - 1));
    assign advance   = !emit || out_free;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            localparam int LEFT  = (i == 0) ? 0 : i - 1;
            localparam int RIGHT = (i + 1) % CAPACITY;
            localparam logic [CNT_W-1:0] POS = CNT_W'(i);

            slid_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .key        (key),
                .occ        (POS < count_reg),
                .left_ge    ((i == 0) ? 1'b0 : ge_vec[LEFT]),
                .left_data  (cell_data[LEFT]),
                .right_data (cell_data[RIGHT]),
                .data       (cell_data[i]),
                .ge         (ge_vec[i]),
                .hit        (hit_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser inside {OP_INSERT, OP_DELETE})
                        state_next = S_EXEC;
                    else if (s_axis_tuser == OP_READ)
                        state_next = empty ? S_EXEC : S_READ;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_READ:
            begin
                if (advance && last_step)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        ctl           = '0;
        key           = value_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_status_next = m_status_reg;
        m_entry_next  = m_entry_reg;
        m_last_next   = m_last_reg;
        m_occ_next    = m_occ_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                key           = s_axis_tdata;
                idx_next      = '0;
                if (accept)
                    ctl.cmp = 1'b1;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_entry_next = '0;
                    m_last_next  = 1'b1;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (full)
                                m_status_next = ST_FULL;
                            else
                            begin
                                ctl.ins       = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                                m_status_next = ST_OK;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (empty)
                                m_status_next = ST_EMPTY;
                            else if (!found)
                                m_status_next = ST_NOT_FOUND;
                            else
                            begin
                                ctl.del       = 1'b1;
                                count_next    = count_reg - CNT_W'(1);
                                m_status_next = ST_OK;
                            end
                        end
                        default:
                        begin
                            m_status_next = ST_EMPTY;
                        end
                    endcase
                    m_occ_next = count_next;
                end
            end
            S_READ:
            begin
                if (advance)
                begin
                    ctl.rot  = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                    if (emit)
                    begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_OK;
                        m_entry_next  = cell_data[0];
                        m_last_next   = (CNT_W'(idx_reg) + CNT_W'(1) == count_reg);
                        m_occ_next    = count_reg;
                    end
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(s_axis_tuser);
            value_reg <= s_axis_tdata;
        end
        m_status_reg <= m_status_next;
        m_entry_reg  <= m_entry_next;
        m_last_reg   <= m_last_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = OUT_W'({m_occ_reg, m_entry_reg, m_status_reg});

endmodule

`default_nettype wire

### hw/rtl/slid_checker.sv
// ----------------------------------------------------------------------------
// Sorted list insert/delete - port checker
// Watches the stream ports of the top level and flags broken behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_list_insert_delete_defines.svh"

module slid_checker
    import slid_pkg::*;
#(
    parameter  int CAPACITY = CAPACITY_DEF,
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int OUT_W    = ((STAT_W + VAL_W + CNT_W + 7) / 8) * 8
)
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic [VAL_W-1:0] s_axis_tdata,   // value
    input wire logic [OP_W-1:0]  s_axis_tuser,   // op
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,   // status, entry, occupancy
    input wire logic             m_axis_tlast    // last
);

    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  entry;
    logic [CNT_W-1:0]  occ;
    logic              in_word;

    assign status  = m_axis_tdata[STAT_W-1:0];
    assign entry   = m_axis_tdata[STAT_W+VAL_W-1:STAT_W];
    assign occ     = m_axis_tdata[STAT_W+VAL_W+CNT_W-1:STAT_W+VAL_W];
    assign in_word = s_axis_tvalid && s_axis_tready
                     && (s_axis_tuser inside {OP_INSERT, OP_DELETE, OP_READ});

    `SLID_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `SLID_ASSERT_NEXT(a_busy_after_word, in_word, !s_axis_tready)
    `SLID_ASSERT_NOW(a_occ_bound, m_axis_tvalid, occ <= CNT_W'(CAPACITY))
    `SLID_ASSERT_NOW(a_error_single, m_axis_tvalid && (status != ST_OK), m_axis_tlast && (entry == '0))

endmodule

bind sorted_list_insert_delete slid_checker #(.CAPACITY(CAPACITY)) u_slid_checker (.*);

`default_nettype wire

### dv/sorted_list_insert_delete_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted list insert/delete - testbench
// Drives insert, delete, read-out and unused op codes through the input stream and
// checks every output word against a sorted-queue predictor of the list,
// under random idling on both sides and forced back-pressure.
// ----------------------------------------------------------------------------

module sorted_list_insert_delete_tb;
    import slid_pkg::*;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
        bit                      pause;
    } cmd_t;

    typedef struct {
        status_t                 status;
        logic signed [VAL_W-1:0] entry;
        logic                    last;
        logic [4:0]              occupancy;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [VAL_W-1:0]      s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    cmd_t                    cmd_queue[$];
    list_result_t            pending_results[$];
    logic signed [VAL_W-1:0] sorted_entries[$];

    int  n_accepted = 0;
    int  n_inserts = 0;
    int  n_deletes = 0;
    int  n_reads = 0;
    int  n_checked = 0;
    int  n_errors = 0;
    int  n_full = 0;
    int  n_missing = 0;
    int  n_empty = 0;
    int  peak_occupancy = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    logic calm;

    assign calm = (n_accepted >= 120) && (n_accepted < 170);

    sorted_list_insert_delete dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_result(status_t status, logic signed [VAL_W-1:0] entry,
                                        logic last);
        list_result_t r;
        r.status    = status;
        r.entry     = entry;
        r.last      = last;
        r.occupancy = 5'(sorted_entries.size());
        pending_results.push_back(r);
    endfunction

    function automatic void apply_list_command(logic [OP_W-1:0] op,
                                               logic signed [VAL_W-1:0] value);
        int pos;
        int idx;
        pos = sorted_entries.size();
        idx = -1;
        case (op)
            OP_INSERT:
            begin
                n_inserts++;
                if (sorted_entries.size() >= CAPACITY_DEF)
                begin
                    n_full++;
                    push_result(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    for (int i = sorted_entries.size() - 1; i >= 0; i--)
                        if (sorted_entries[i] >= value)
                            pos = i;
                    sorted_entries.insert(pos, value);
                    if (sorted_entries.size() > peak_occupancy)
                        peak_occupancy = sorted_entries.size();
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            OP_DELETE:
            begin
                n_deletes++;
                if (sorted_entries.size() == 0)
                begin
                    n_empty++;
                    push_result(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (int i = sorted_entries.size() - 1; i >= 0; i--)
                        if (sorted_entries[i] == value)
                            idx = i;
                    if (idx < 0)
                    begin
                        n_missing++;
                        push_result(ST_NOT_FOUND, '0, 1'b1);
                    end
                    else
                    begin
                        sorted_entries.delete(idx);
                        push_result(ST_OK, '0, 1'b1);
                    end
                end
            end
            OP_READ:
            begin
                n_reads++;
                if (sorted_entries.size() == 0)
                begin
                    n_empty++;
                    push_result(ST_EMPTY, '0, 1'b1);
                end
                else
                    for (int i = 0; i < sorted_entries.size(); i++)
                        push_result(ST_OK, sorted_entries[i],
                                    i == sorted_entries.size() - 1);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        cmd_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_list_command(s_axis_tuser, s_axis_tdata);
                n_accepted++;
            end
            // hold the word until it is taken
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (cmd_queue.size() != 0
                    && !(cmd_queue[0].pause && pending_results.size() != 0)
                    && !(!calm && $urandom_range(99) < 24))
                begin
                    nxt = cmd_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.value;
                    s_axis_tuser  <= nxt.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        list_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_checked++;
                if (pending_results.size() == 0)
                begin
                    n_errors++;
                    $display("[%0t] unexpected result word 0x%04h", $time, m_axis_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[1:0] !== want.status)
                        report_mismatch("status", m_axis_tdata[1:0], want.status);
                    if (m_axis_tdata[9:2] !== want.entry)
                        report_mismatch("entry", $signed(m_axis_tdata[9:2]), want.entry);
                    if (m_axis_tdata[14:10] !== want.occupancy)
                        report_mismatch("occupancy", m_axis_tdata[14:10], want.occupancy);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && n_accepted >= 60)
            begin
                hold_done <= 1'b1;
                hold_left <= 150;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    task automatic add_cmd(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value,
                           bit pause = 0);
        cmd_t c;
        c.op    = op;
        c.value = value;
        c.pause = pause;
        cmd_queue.push_back(c);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 70)
            return VAL_W'($urandom_range(15) + 248);
        return VAL_W'($urandom_range(255));
    endfunction

    initial
    begin
        int n_real;
        int mode;
        int roll;
        int ins_pct;
        int del_pct;
        bit pause_next;
        logic [OP_W-1:0] op;

        add_cmd(OP_READ, 8'sd0);
        add_cmd(OP_DELETE, 8'sd3);
        add_cmd(OP_INSERT, 8'sd5);
        add_cmd(OP_DELETE, 8'sd5);
        add_cmd(OP_INSERT, 8'sd127);
        add_cmd(OP_INSERT, -8'sd128);
        add_cmd(OP_INSERT, -8'sd128);
        add_cmd(OP_DELETE, 8'sd55);
        add_cmd(2'd3, -8'sd1);
        for (int i = 0; i < 13; i++)
            add_cmd(OP_INSERT, VAL_W'(-64 + (i % 7) * 20));
        add_cmd(OP_INSERT, 8'sd1);
        add_cmd(OP_READ, 8'sd0);

        n_real = 0;
        pause_next = 1;
        while (n_real < 236)
        begin
            mode = (n_real / 40) % 3;
            ins_pct = (mode == 0) ? 60 : (mode == 1) ? 20 : 38;
            del_pct = (mode == 0) ? 20 : (mode == 1) ? 62 : 38;
            roll = $urandom_range(99);
            if ($urandom_range(99) < 3)
                op = 2'd3;
            else if (roll < ins_pct)
                op = OP_INSERT;
            else if (roll < ins_pct + del_pct)
                op = OP_DELETE;
            else
                op = OP_READ;
            add_cmd(op, pick_value(), pause_next);
            pause_next = 0;
            if (op != 2'd3)
            begin
                n_real++;
                if (n_real % 40 == 0)
                    pause_next = 1;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Ran %0d commands: %0d insert, %0d delete, %0d read-out; %0d words checked.",
                 n_accepted, n_inserts, n_deletes, n_reads, n_checked);
        $display("Full %0d, not found %0d, empty %0d; occupancy peaked at %0d.",
                 n_full, n_missing, n_empty, peak_occupancy);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/slid_pkg.sv
hw/rtl/slid_cell.sv
hw/rtl/sorted_list_insert_delete.sv
hw/rtl/slid_checker.sv
dv/sorted_list_insert_delete_tb.sv
